// ----- rtl/core/sct_pkg.sv -----
// sct_pkg: constants, widths and the sine/cosine table for the table-plus-taylor block
// shared by every module under rtl/core; depends on nothing
package sct_pkg;

  // table and fixed-point format
  localparam int TABLE_SIZE = 256;
  localparam int TABLE_BITS = $clog2(TABLE_SIZE);
  localparam int FRAC_BITS  = 16;

  // port field widths
  localparam int ANGLE_W    = 32;
  localparam int OUT_W      = 18;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 40;

  // internal widths, work values are q30
  localparam int MAG_W      = 32;
  localparam int FRAC_W     = 32;
  localparam int WORK_W     = 32;

  // 1/(2*pi) in q64, split in halves for two 32x32 multipliers
  localparam logic [MAG_W-1:0] INV_2PI_HI = 32'h28BE60DB;
  localparam logic [MAG_W-1:0] INV_2PI_LO = 32'h9391054A;

  // radians per table step, q30 after the 34-bit shift
  localparam longint unsigned TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam longint unsigned STEP_FULL  = (TWO_PI_Q60 / TABLE_SIZE) >> 28;
  localparam int STEP_W = $clog2(STEP_FULL + 1);
  localparam logic [STEP_W-1:0] STEP = STEP_W'(STEP_FULL);

  // fraction angle and its powers
  localparam int B_W   = STEP_W - 2;
  localparam int B2_W  = 2 * B_W - 30;
  localparam int B3_W  = B_W + B2_W - 30;
  localparam int CB_W  = 31;

  // taylor coefficients in q30
  localparam int KS_W  = 28;
  localparam int K120_W = 24;
  localparam int KC_W  = 30;
  localparam int K24_W = 26;
  localparam logic [KS_W-1:0]   K_SIXTH = 28'd178956971;
  localparam logic [K120_W-1:0] K_120TH = 24'd8947849;
  localparam logic [KC_W-1:0]   K_HALF  = 30'd536870912;
  localparam logic [K24_W-1:0]  K_24TH  = 26'd44739243;
  localparam logic [CB_W-1:0]   WORK_ONE = 31'd1073741824;

  // stage counts of the three datapath sections
  localparam int REDUCE_LAT  = 3;
  localparam int POLY_LAT    = 4;
  localparam int COMBINE_LAT = 3;
  localparam int PIPE_LAT    = REDUCE_LAT + POLY_LAT + COMBINE_LAT;

  // term divisors of the table generator, (2k)(2k+1) for sine and (2k-1)(2k) for cosine
  localparam int TERM_COUNT = 11;
  localparam longint unsigned SIN_TERM_DIV [TERM_COUNT] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420,
    64'd506
  };
  localparam longint unsigned COS_TERM_DIV [TERM_COUNT] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380,
    64'd462
  };

  typedef logic [TABLE_SIZE-1:0][WORK_W-1:0] rom_t;

  // one table entry, sin or cos of 2*pi*i/TABLE_SIZE in q30
  function automatic logic [WORK_W-1:0] rom_entry(input int i, input logic want_cos);
    longint unsigned q4;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    longint ss;
    longint cc;
    longint s_out;
    longint c_out;
    q4   = longint'(i % TABLE_SIZE) * 4;
    quad = q4 / TABLE_SIZE;
    r    = q4 % TABLE_SIZE;
    x    = (64'd1686629713 * r) / TABLE_SIZE;
    x2   = (x * x) >> 30;
    ts   = x;
    tc   = 64'd1 << 30;
    ss   = longint'(x);
    cc   = longint'(64'd1 << 30);
    // first term subtracts, signs alternate from there
    for (int k = 0; k < TERM_COUNT; k++) begin
      ts = ((ts * x2) >> 30) / SIN_TERM_DIV[k];
      tc = ((tc * x2) >> 30) / COS_TERM_DIV[k];
      if (k[0] == 1'b0) begin
        ss = ss - longint'(ts);
        cc = cc - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cc = cc + longint'(tc);
      end
    end
    if (ss < 0) ss = 0;
    if (ss > (longint'(1) << 30)) ss = longint'(1) << 30;
    if (cc < 0) cc = 0;
    if (cc > (longint'(1) << 30)) cc = longint'(1) << 30;
    case (quad)
      64'd0: begin
        s_out = ss;
        c_out = cc;
      end
      64'd1: begin
        s_out = cc;
        c_out = -ss;
      end
      64'd2: begin
        s_out = -ss;
        c_out = -cc;
      end
      default: begin
        s_out = -cc;
        c_out = ss;
      end
    endcase
    return want_cos ? WORK_W'(c_out) : WORK_W'(s_out);
  endfunction

  function automatic rom_t build_rom(input logic want_cos);
    rom_t rom;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      rom[i] = rom_entry(i, want_cos);
    end
    return rom;
  endfunction

endpackage

// ----- rtl/core/sct_reduce.sv -----
// sct_reduce: angle magnitude, scaling by TABLE_SIZE/(2*pi), split into table index and fraction
// three register stages; depends on sct_pkg
module sct_reduce (
  input  logic                            clk,
  input  logic                            en,
  input  logic [sct_pkg::ANGLE_W-1:0]     angle,
  output logic [sct_pkg::TABLE_BITS-1:0]  idx,
  output logic [sct_pkg::FRAC_W-1:0]      frac
);
  import sct_pkg::*;

  localparam int PROD_W = 2 * MAG_W;
  // position of the fraction within the upper sum (product bits shifted by TABLE_BITS)
  localparam int SUM_LO = FRAC_BITS - TABLE_BITS;

  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mag_next;
  logic [PROD_W-1:0] pa;
  logic [PROD_W-1:0] pb;
  logic [PROD_W-1:0] sum;

  // most negative angle comes out as 2^31 unsigned
  always_comb begin
    mag_next = angle[ANGLE_W-1] ? MAG_W'(~angle + 1'b1) : MAG_W'(angle);
  end

  // low half of pb only feeds bits below the fraction, no carry reaches the upper sum
  assign sum = pa + {{MAG_W{1'b0}}, pb[PROD_W-1:MAG_W]};

  always_ff @(posedge clk) begin
    if (en) begin
      mag  <= mag_next;
      pa   <= PROD_W'(mag) * PROD_W'(INV_2PI_HI);
      pb   <= PROD_W'(mag) * PROD_W'(INV_2PI_LO);
      idx  <= sum[SUM_LO+FRAC_W +: TABLE_BITS];
      frac <= sum[SUM_LO +: FRAC_W];
    end
  end

endmodule

// ----- rtl/core/sct_poly.sv -----
// sct_poly: fraction to radians and short taylor polynomials for its sine and cosine
// four register stages; depends on sct_pkg
module sct_poly (
  input  logic                       clk,
  input  logic                       en,
  input  logic [sct_pkg::FRAC_W-1:0] frac,
  output logic [sct_pkg::B_W-1:0]    sb,
  output logic [sct_pkg::CB_W-1:0]   cb
);
  import sct_pkg::*;

  localparam int PB_W   = FRAC_W + STEP_W;
  localparam int PBB_W  = 2 * B_W;
  localparam int PB3_W  = B_W + B2_W;
  localparam int P120_W = B2_W + K120_W;
  localparam int P24_W  = B2_W + K24_W;
  localparam int PS_W   = B3_W + KS_W;
  localparam int PC_W   = B2_W + KC_W;

  logic [B_W-1:0]    b;
  logic [B_W-1:0]    b_d1;
  logic [B_W-1:0]    b_d2;
  logic [B2_W-1:0]   b2;
  logic [B2_W-1:0]   b2_d;
  logic [B3_W-1:0]   b3;
  logic [KS_W-1:0]   ks;
  logic [KC_W-1:0]   kc;
  logic [PB_W-1:0]   prod_b;
  logic [PBB_W-1:0]  prod_bb;
  logic [PB3_W-1:0]  prod_b3;
  logic [P120_W-1:0] prod_120;
  logic [P24_W-1:0]  prod_24;
  logic [PS_W-1:0]   prod_s;
  logic [PC_W-1:0]   prod_c;

  always_comb begin
    prod_b   = PB_W'(frac) * PB_W'(STEP);
    prod_bb  = PBB_W'(b) * PBB_W'(b);
    prod_b3  = PB3_W'(b_d1) * PB3_W'(b2);
    prod_120 = P120_W'(b2) * P120_W'(K_120TH);
    prod_24  = P24_W'(b2) * P24_W'(K_24TH);
    prod_s   = PS_W'(b3) * PS_W'(ks);
    prod_c   = PC_W'(b2_d) * PC_W'(kc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b    <= prod_b[34 +: B_W];
      b_d1 <= b;
      b2   <= prod_bb[30 +: B2_W];
      b_d2 <= b_d1;
      b2_d <= b2;
      b3   <= prod_b3[30 +: B3_W];
      ks   <= K_SIXTH - KS_W'(prod_120[P120_W-1:30]);
      kc   <= K_HALF - KC_W'(prod_24[P24_W-1:30]);
      sb   <= b_d2 - B_W'(prod_s[PS_W-1:30]);
      cb   <= WORK_ONE - CB_W'(prod_c[PC_W-1:30]);
    end
  end

endmodule

// ----- rtl/core/sct_rom.sv -----
// sct_rom: registered sine/cosine table read, delayed to line up with the polynomial path
// depends on sct_pkg (table contents built at elaboration)
module sct_rom (
  input  logic                                clk,
  input  logic                                en,
  input  logic [sct_pkg::TABLE_BITS-1:0]      idx,
  output logic signed [sct_pkg::WORK_W-1:0]   rs,
  output logic signed [sct_pkg::WORK_W-1:0]   rc
);
  import sct_pkg::*;

  localparam rom_t SIN_ROM = build_rom(1'b0);
  localparam rom_t COS_ROM = build_rom(1'b1);

  logic signed [WORK_W-1:0] rs_pipe [POLY_LAT];
  logic signed [WORK_W-1:0] rc_pipe [POLY_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      rs_pipe[0] <= $signed(SIN_ROM[idx]);
      rc_pipe[0] <= $signed(COS_ROM[idx]);
      for (int k = 1; k < POLY_LAT; k++) begin
        rs_pipe[k] <= rs_pipe[k-1];
        rc_pipe[k] <= rc_pipe[k-1];
      end
    end
  end

  assign rs = rs_pipe[POLY_LAT-1];
  assign rc = rc_pipe[POLY_LAT-1];

endmodule

// ----- rtl/core/sct_combine.sv -----
// sct_combine: angle-addition products, sum, rounding to the output format, saturation, sign
// three register stages; depends on sct_pkg
module sct_combine (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [sct_pkg::WORK_W-1:0] rs,
  input  logic signed [sct_pkg::WORK_W-1:0] rc,
  input  logic [sct_pkg::B_W-1:0]           sb,
  input  logic [sct_pkg::CB_W-1:0]          cb,
  input  logic                              neg,
  output logic [sct_pkg::OUT_W-1:0]         sin_value,
  output logic [sct_pkg::OUT_W-1:0]         cos_value
);
  import sct_pkg::*;

  localparam int P_W   = 64;
  localparam int SHIFT = 60 - FRAC_BITS;
  localparam int V_W   = P_W - SHIFT;
  localparam logic signed [P_W-1:0] ROUND   = P_W'(64'd1 << (SHIFT - 1));
  localparam logic signed [V_W-1:0] LIM     = V_W'(64'd1 << FRAC_BITS);
  localparam logic signed [V_W-1:0] NEG_LIM = -LIM;

  logic signed [CB_W:0]    cb_s;
  logic signed [B_W:0]     sb_s;
  logic signed [P_W-1:0]   p_sc;
  logic signed [P_W-1:0]   p_cs;
  logic signed [P_W-1:0]   p_cc;
  logic signed [P_W-1:0]   p_ss;
  logic signed [P_W-1:0]   sv_sum;
  logic signed [P_W-1:0]   cv_sum;
  logic signed [P_W-1:0]   sv_rnd;
  logic signed [P_W-1:0]   cv_rnd;
  logic signed [V_W-1:0]   sv_sat;
  logic signed [V_W-1:0]   cv_sat;
  logic signed [V_W-1:0]   sv_out;

  function automatic logic signed [V_W-1:0] sat(input logic signed [P_W-1:0] v);
    logic signed [V_W-1:0] q;
    q = V_W'(v >>> SHIFT);
    if (q > LIM) begin
      q = LIM;
    end else if (q < NEG_LIM) begin
      q = NEG_LIM;
    end
    return q;
  endfunction

  always_comb begin
    cb_s   = $signed({1'b0, cb});
    sb_s   = $signed({1'b0, sb});
    // round half up, then floor
    sv_rnd = sv_sum + ROUND;
    cv_rnd = cv_sum + ROUND;
    sv_sat = sat(sv_rnd);
    cv_sat = sat(cv_rnd);
    sv_out = neg ? -sv_sat : sv_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_sc      <= P_W'(rs) * P_W'(cb_s);
      p_cs      <= P_W'(rc) * P_W'(sb_s);
      p_cc      <= P_W'(rc) * P_W'(cb_s);
      p_ss      <= P_W'(rs) * P_W'(sb_s);
      sv_sum    <= p_sc + p_cs;
      cv_sum    <= p_cc - p_ss;
      sin_value <= OUT_W'(sv_out);
      cos_value <= OUT_W'(cv_sat);
    end
  end

endmodule

// ----- rtl/core/sine_cosine_table_taylor.sv -----
// sine_cosine_table_taylor: top level, pipeline valid/sign tracking and stream ports
// depends on sct_pkg, sct_reduce, sct_poly, sct_rom, sct_combine
//
//   channel   direction  payload (tdata, lowest bit first)
//   s_*       in         angle[31:0] q16.16 radians
//   m_*       out        sin_value[17:0], cos_value[35:18], zero[39:36], both q1.16
//
// ten register stages from an accepted transaction to its result on m_tdata.
// one transaction per cycle sustained while m_tready stays high; the stage count is set by the multipliers,
// each followed by a register, in reduction, polynomial and combine sections.
// when the result register holds a transaction and m_tready is low, every stage holds.
// reset clears only the valid bits; the table is constant and needs no clearing.
module sine_cosine_table_taylor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sct_pkg::S_TDATA_W-1:0]     s_tdata,  // angle[31:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sct_pkg::M_TDATA_W-1:0]     m_tdata   // sin_value[17:0], cos_value[35:18]
);
  import sct_pkg::*;

  typedef struct packed {
    logic valid;
    logic neg;
  } ctl_t;

  ctl_t ctl [PIPE_LAT];

  logic                     en;
  logic [TABLE_BITS-1:0]    idx;
  logic [FRAC_W-1:0]        frac;
  logic [B_W-1:0]           sb;
  logic [CB_W-1:0]          cb;
  logic signed [WORK_W-1:0] rs;
  logic signed [WORK_W-1:0] rc;
  logic [OUT_W-1:0]         sin_value;
  logic [OUT_W-1:0]         cos_value;

  // whole pipeline advances unless a finished transaction is waiting
  assign en       = ~ctl[PIPE_LAT-1].valid | m_tready;
  assign s_tready = en;
  assign m_tvalid = ctl[PIPE_LAT-1].valid;
  assign m_tdata  = {{(M_TDATA_W - 2 * OUT_W){1'b0}}, cos_value, sin_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_LAT; k++) begin
        ctl[k].valid <= 1'b0;
      end
    end else if (en) begin
      ctl[0].valid <= s_tvalid;
      ctl[0].neg   <= s_tdata[ANGLE_W-1];
      for (int k = 1; k < PIPE_LAT; k++) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  sct_reduce u_reduce (
    .clk   (clk),
    .en    (en),
    .angle (s_tdata[ANGLE_W-1:0]),
    .idx   (idx),
    .frac  (frac)
  );

  sct_poly u_poly (
    .clk  (clk),
    .en   (en),
    .frac (frac),
    .sb   (sb),
    .cb   (cb)
  );

  sct_rom u_rom (
    .clk (clk),
    .en  (en),
    .idx (idx),
    .rs  (rs),
    .rc  (rc)
  );

  // sign is applied in the last stage, so take it from the stage before
  sct_combine u_combine (
    .clk       (clk),
    .en        (en),
    .rs        (rs),
    .rc        (rc),
    .sb        (sb),
    .cb        (cb),
    .neg       (ctl[PIPE_LAT-2].neg),
    .sin_value (sin_value),
    .cos_value (cos_value)
  );

endmodule
